// ----- design/assert_macros.svh -----
// Assertion macros shared by the tokenizer RTL.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be seen at a clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  `ASSERT_CLK(label, clk, rst_n, !(cond), msg)

`endif

// ----- design/stok_pkg.sv -----
// Shared types, constants and byte classes for the source tokenizer.
// Used by stok_front, stok_queue, stok_back and source_tokenizer.
package stok_pkg;

  // Longest source; the byte at offset MAX_SOURCE_BYTES - 1 ends a source.
  localparam int unsigned MAX_SOURCE_BYTES = 65535;
  localparam int unsigned OFS_W = 16;
  localparam logic [OFS_W-1:0] LAST_OFS = OFS_W'(MAX_SOURCE_BYTES - 1);

  // Result queue between the front and back parts.
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);

  // Character codes with special meaning.
  localparam logic [7:0] CHAR_HASH   = 8'h23;
  localparam logic [7:0] CHAR_US     = 8'h5F;
  localparam logic [7:0] CHAR_QUOTE  = 8'h22;
  localparam logic [7:0] CHAR_BSLASH = 8'h5C;
  localparam logic [7:0] CHAR_NL     = 8'h0A;

  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_WS      = 3'd1,
    MODE_COMMENT = 3'd2,
    MODE_SYMBOL  = 3'd3,
    MODE_INT     = 3'd4,
    MODE_STR     = 3'd5,
    MODE_ESC     = 3'd6
  } scan_mode_e;

  typedef enum logic [2:0] {
    KIND_WS      = 3'd0,
    KIND_COMMENT = 3'd1,
    KIND_SYMBOL  = 3'd2,
    KIND_INT     = 3'd3,
    KIND_STRING  = 3'd4,
    KIND_CHAR    = 3'd5
  } tok_kind_e;

  typedef struct packed {
    tok_kind_e        kind;
    logic [7:0]       ch;
    logic [OFS_W-1:0] start_ofs;
    logic [OFS_W-1:0] end_ofs;
  } tok_t;

  // All tokens caused by one byte: one or two.
  typedef struct packed {
    logic two;
    tok_t tok1;
    tok_t tok0;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic is_ws(input logic [7:0] c);
    return c inside {8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};
  endfunction

  function automatic logic is_dig(input logic [7:0] c);
    return c inside {[8'h30:8'h39]};
  endfunction

  function automatic logic is_alpha_us(input logic [7:0] c);
    return c inside {[8'h61:8'h7A], [8'h41:8'h5A], CHAR_US};
  endfunction

  // Does byte c extend the run of the given mode?
  function automatic logic run_continues(input scan_mode_e m, input logic [7:0] c);
    case (m)
      MODE_WS:      return is_ws(c);
      MODE_COMMENT: return c != CHAR_NL;
      MODE_SYMBOL:  return is_alpha_us(c) || is_dig(c);
      MODE_INT:     return is_dig(c);
      default:      return 1'b0;
    endcase
  endfunction

  // Mode opened by a byte that starts a token; idle means single character.
  function automatic scan_mode_e start_mode(input logic [7:0] c);
    if (is_ws(c))            return MODE_WS;
    else if (c == CHAR_HASH) return MODE_COMMENT;
    else if (is_alpha_us(c)) return MODE_SYMBOL;
    else if (is_dig(c))      return MODE_INT;
    else if (c == CHAR_QUOTE) return MODE_STR;
    else                     return MODE_IDLE;
  endfunction

  function automatic tok_kind_e kind_of(input scan_mode_e m);
    case (m)
      MODE_WS:      return KIND_WS;
      MODE_COMMENT: return KIND_COMMENT;
      MODE_SYMBOL:  return KIND_SYMBOL;
      MODE_INT:     return KIND_INT;
      MODE_STR:     return KIND_STRING;
      MODE_ESC:     return KIND_STRING;
      default:      return KIND_CHAR;
    endcase
  endfunction

endpackage

// ----- design/stok_front.sv -----
// Front part: accepts source bytes, runs the scan state machine and
// pushes the tokens each byte causes into the queue. Depends on stok_pkg.
module stok_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             src_valid_i,
  output logic             src_stall_o,
  input  logic [7:0]       src_byte_i,
  input  logic             final_byte_i,
  input  stok_pkg::q_stat_t q_stat_i,
  output logic             push_o,
  output stok_pkg::entry_t push_entry_o
);
  import stok_pkg::*;

  scan_mode_e       mode_q, mode_d;
  logic [OFS_W-1:0] begin_q, begin_d;
  logic [OFS_W-1:0] offset_q, offset_d;

  logic             accept;
  logic             last;
  logic [OFS_W-1:0] p_next;
  logic             start;
  scan_mode_e       mode_mid;
  scan_mode_e       mode_new;
  scan_mode_e       mode_after;
  logic [OFS_W-1:0] begin_after;
  logic             emit_a, emit_s, emit_f;
  tok_t             tok_a, tok_s, tok_f;

  assign src_stall_o = q_stat_i.full;
  assign accept      = src_valid_i && !q_stat_i.full;
  assign last        = final_byte_i || (offset_q >= LAST_OFS);
  assign p_next      = offset_q + OFS_W'(1);

  // Close or extend the open run
  always_comb begin
    start    = 1'b0;
    mode_mid = mode_q;
    emit_a   = 1'b0;
    tok_a    = '{kind: kind_of(mode_q), ch: 8'h00, start_ofs: begin_q, end_ofs: offset_q};
    case (mode_q)
      MODE_WS, MODE_COMMENT, MODE_SYMBOL, MODE_INT: begin
        if (!run_continues(mode_q, src_byte_i)) begin
          emit_a   = 1'b1;
          mode_mid = MODE_IDLE;
          start    = 1'b1;
        end
      end
      MODE_STR: begin
        if (src_byte_i == CHAR_BSLASH) begin
          mode_mid = MODE_ESC;
        end else if (src_byte_i == CHAR_QUOTE) begin
          emit_a        = 1'b1;
          tok_a.kind    = KIND_STRING;
          tok_a.end_ofs = p_next;
          mode_mid      = MODE_IDLE;
        end
      end
      MODE_ESC: begin
        mode_mid = MODE_STR;
      end
      default: begin
        mode_mid = MODE_IDLE;
        start    = 1'b1;
      end
    endcase
    mode_new    = start_mode(src_byte_i);
    mode_after  = start ? mode_new : mode_mid;
    begin_after = start ? offset_q : begin_q;
  end

  // Next state
  always_comb begin
    mode_d   = mode_q;
    begin_d  = begin_q;
    offset_d = offset_q;
    if (accept) begin
      if (last) begin
        mode_d   = MODE_IDLE;
        begin_d  = '0;
        offset_d = '0;
      end else begin
        mode_d   = mode_after;
        begin_d  = begin_after;
        offset_d = p_next;
      end
    end
  end

  // Outputs: single character token, flush at the last byte, queue entry
  always_comb begin
    emit_s = start && (mode_new == MODE_IDLE);
    tok_s  = '{kind: KIND_CHAR, ch: src_byte_i, start_ofs: offset_q, end_ofs: p_next};
    emit_f = last && (mode_after != MODE_IDLE);
    tok_f  = '{kind: kind_of(mode_after), ch: 8'h00, start_ofs: begin_after,
               end_ofs: p_next};
    push_entry_o.tok0 = emit_a ? tok_a : (emit_s ? tok_s : tok_f);
    push_entry_o.tok1 = emit_s ? tok_s : tok_f;
    push_entry_o.two  = emit_a && (emit_s || emit_f);
    push_o            = accept && (emit_a || emit_s || emit_f);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_IDLE;
      begin_q  <= '0;
      offset_q <= '0;
    end else begin
      mode_q   <= mode_d;
      begin_q  <= begin_d;
      offset_q <= offset_d;
    end
  end

endmodule

// ----- design/stok_queue.sv -----
// Small FIFO of per-byte token entries between front and back parts.
// Depends on stok_pkg for the entry type and depth.
module stok_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  stok_pkg::entry_t  push_entry_i,
  input  logic              pop_i,
  output stok_pkg::entry_t  head_o,
  output stok_pkg::q_stat_t stat_o
);
  import stok_pkg::*;

  entry_t              entries_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0]   count_q, count_d;
  logic                do_push, do_pop;

  assign stat_o.full  = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign stat_o.empty = (count_q == '0);
  assign head_o       = entries_q[rd_ptr_q];

  // Drop pushes when full and pops when empty
  assign do_push = push_i && !stat_o.full;
  assign do_pop  = pop_i && !stat_o.empty;

  // Advance pointers and level
  always_comb begin
    wr_ptr_d = do_push ? QPTR_W'(wr_ptr_q + QPTR_W'(1)) : wr_ptr_q;
    rd_ptr_d = do_pop  ? QPTR_W'(rd_ptr_q + QPTR_W'(1)) : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store entries
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= push_entry_i;
    end
  end

endmodule

// ----- design/stok_back.sv -----
// Back part: takes queue entries apart into single tokens and holds each
// in the output register until taken. Depends on stok_pkg.
module stok_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  stok_pkg::entry_t  head_i,
  input  stok_pkg::q_stat_t q_stat_i,
  output logic              pop_o,
  output logic              tok_valid_o,
  input  logic              tok_stall_i,
  output stok_pkg::tok_t    tok_o,
  output logic              last_of_run_o
);
  import stok_pkg::*;

  logic   valid_q, valid_d;
  logic   sel_q, sel_d;
  tok_t   tok_q;
  logic   last_q;
  logic   load;
  logic   head_last;

  assign tok_valid_o   = valid_q;
  assign tok_o         = tok_q;
  assign last_of_run_o = last_q;

  // Load the next token when the output register is free or being taken
  assign load      = !q_stat_i.empty && (!valid_q || !tok_stall_i);
  assign head_last = sel_q || !head_i.two;
  assign pop_o     = load && head_last;

  always_comb begin
    valid_d = valid_q;
    sel_d   = sel_q;
    if (load) begin
      valid_d = 1'b1;
      sel_d   = !head_last;
    end else if (!tok_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      sel_q   <= 1'b0;
    end else begin
      valid_q <= valid_d;
      sel_q   <= sel_d;
    end
  end

  // Hold payload until taken
  always_ff @(posedge clk_i) begin
    if (load) begin
      tok_q  <= sel_q ? head_i.tok1 : head_i.tok0;
      last_q <= head_last;
    end
  end

endmodule

// ----- design/source_tokenizer.sv -----
// Source tokenizer top level: source bytes in, tokens out.
// Channels: src (src_byte_i, final_byte_i) and tok (kind, char, offsets,
// last_of_run); each uses valid and stall, an item moves when valid is
// high and stall is low.
// A byte is taken every cycle while the result queue has room. A byte
// that causes tokens writes one entry into the result queue, and the
// output register loads its first token from the head of the queue; a
// byte causing two tokens offers them one after the other from the single
// output register. Bytes causing no token give nothing.
// The four-entry queue between the scanner and the output stage absorbs
// stalls: while tok_stall_i is high the output holds, the queue fills, and
// src_stall_o rises once all four entries are in use.
// final_byte_i flushes the open token and rewinds offsets to zero; a byte
// at offset 65534 ends the source the same way.
// Reset empties the queue, drops the output and returns the scanner to
// idle at offset zero. last_of_run_o marks the last token of a byte.
// Depends on stok_pkg, stok_front, stok_queue, stok_back, assert_macros.svh.
`include "assert_macros.svh"

module source_tokenizer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        src_valid_i,
  output logic        src_stall_o,
  input  logic [7:0]  src_byte_i,
  input  logic        final_byte_i,
  output logic        tok_valid_o,
  input  logic        tok_stall_i,
  output logic [2:0]  tok_kind_o,
  output logic [7:0]  tok_char_o,
  output logic [15:0] tok_start_o,
  output logic [15:0] tok_end_o,
  output logic        last_of_run_o
);
  import stok_pkg::*;

  logic    push;
  entry_t  push_entry;
  logic    pop;
  entry_t  head;
  q_stat_t q_stat;
  tok_t    tok;

  stok_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .src_valid_i  (src_valid_i),
    .src_stall_o  (src_stall_o),
    .src_byte_i   (src_byte_i),
    .final_byte_i (final_byte_i),
    .q_stat_i     (q_stat),
    .push_o       (push),
    .push_entry_o (push_entry)
  );

  stok_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .pop_i        (pop),
    .head_o       (head),
    .stat_o       (q_stat)
  );

  stok_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head),
    .q_stat_i      (q_stat),
    .pop_o         (pop),
    .tok_valid_o   (tok_valid_o),
    .tok_stall_i   (tok_stall_i),
    .tok_o         (tok),
    .last_of_run_o (last_of_run_o)
  );

  assign tok_kind_o  = 3'(tok.kind);
  assign tok_char_o  = tok.ch;
  assign tok_start_o = tok.start_ofs;
  assign tok_end_o   = tok.end_ofs;

  // Checks
  `ASSERT_NEVER(a_push_full, clk_i, rst_ni, push && q_stat.full,
    "front pushed into a full queue")
  `ASSERT_NEVER(a_pop_empty, clk_i, rst_ni, pop && q_stat.empty,
    "back popped an empty queue")
  `ASSERT_CLK(a_tok_nonempty, clk_i, rst_ni, tok_valid_o |-> (tok_end_o > tok_start_o),
    "token ends at or before its start")

endmodule

// ----- verif/source_tokenizer_tb.sv -----
// Self-checking testbench for source_tokenizer: streams source bytes and checks every token.
// Token predictions come from a scoreboard class inside this file.
// Depends on stok_pkg and the source_tokenizer RTL only.
module source_tokenizer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import stok_pkg::*;

  localparam int unsigned SRC_ITEMS    = 1420;
  localparam int unsigned CYCLE_LIMIT  = 800_000;
  localparam int unsigned DRAIN_CYCLES = 16;

  // Scoreboard: scans accepted bytes and holds the tokens still owed
  class token_ledger;
    typedef struct {
      tok_kind_e   kind;
      logic [7:0]  ch;
      logic [15:0] start_ofs;
      logic [15:0] end_ofs;
      logic        last;
    } token_t;

    scan_mode_e  mode;
    int unsigned tok_begin;
    int unsigned byte_ofs;
    token_t      pending_toks[$];
    int unsigned errors;

    function new();
      mode      = MODE_IDLE;
      tok_begin = 0;
      byte_ofs  = 0;
      errors    = 0;
    endfunction

    static function bit is_blank(logic [7:0] c);
      return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    static function bit is_numeral(logic [7:0] c);
      return c >= 8'h30 && c <= 8'h39;
    endfunction

    static function bit is_word_head(logic [7:0] c);
      return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || c == CHAR_US;
    endfunction

    function tok_kind_e kind_for(scan_mode_e m);
      case (m)
        MODE_WS:           return KIND_WS;
        MODE_COMMENT:      return KIND_COMMENT;
        MODE_SYMBOL:       return KIND_SYMBOL;
        MODE_INT:          return KIND_INT;
        MODE_STR, MODE_ESC: return KIND_STRING;
        default:           return KIND_CHAR;
      endcase
    endfunction

    function void add_token(tok_kind_e k, logic [7:0] ch, int unsigned s, int unsigned e);
      token_t t;
      t.kind      = k;
      t.ch        = ch;
      t.start_ofs = s[15:0];
      t.end_ofs   = e[15:0];
      t.last      = 1'b0;
      pending_toks.push_back(t);
    endfunction

    // Advance the scanner by one byte and queue the tokens it causes
    function void scan_byte(logic [7:0] c, logic fin);
      int unsigned p;
      int unsigned n_old;
      bit          last_byte;
      bit          opening;
      bit          breaks;
      p         = byte_ofs;
      n_old     = pending_toks.size();
      last_byte = fin || (p + 1 >= MAX_SOURCE_BYTES);
      opening   = 1'b0;
      breaks    = 1'b0;

      case (mode)
        MODE_WS, MODE_COMMENT, MODE_SYMBOL, MODE_INT: begin
          case (mode)
            MODE_WS:      breaks = !is_blank(c);
            MODE_COMMENT: breaks = (c == CHAR_NL);
            MODE_SYMBOL:  breaks = !(is_word_head(c) || is_numeral(c));
            default:      breaks = !is_numeral(c);
          endcase
          if (breaks) begin
            add_token(kind_for(mode), 8'h00, tok_begin, p);
            mode    = MODE_IDLE;
            opening = 1'b1;
          end
        end
        MODE_STR: begin
          if (c == CHAR_BSLASH) begin
            mode = MODE_ESC;
          end else if (c == CHAR_QUOTE) begin
            add_token(KIND_STRING, 8'h00, tok_begin, p + 1);
            mode = MODE_IDLE;
          end
        end
        MODE_ESC: mode = MODE_STR;
        default: begin
          mode    = MODE_IDLE;
          opening = 1'b1;
        end
      endcase

      // Open the token this byte starts, or emit it as a single character
      if (opening) begin
        tok_begin = p;
        if (is_blank(c))           mode = MODE_WS;
        else if (c == CHAR_HASH)   mode = MODE_COMMENT;
        else if (is_word_head(c))  mode = MODE_SYMBOL;
        else if (is_numeral(c))    mode = MODE_INT;
        else if (c == CHAR_QUOTE)  mode = MODE_STR;
        else                       add_token(KIND_CHAR, c, p, p + 1);
      end

      // Flush the open token at the end of a source and rewind
      if (last_byte) begin
        if (mode != MODE_IDLE) begin
          add_token(kind_for(mode), 8'h00, tok_begin, p + 1);
          mode = MODE_IDLE;
        end
        byte_ofs  = 0;
        tok_begin = 0;
      end else begin
        byte_ofs = p + 1;
      end

      if (pending_toks.size() > n_old) pending_toks[pending_toks.size() - 1].last = 1'b1;
    endfunction

    function int unsigned outstanding();
      return pending_toks.size();
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    // Check one delivered token against the oldest one owed
    function void match_token(logic [2:0] kind, logic [7:0] ch, logic [15:0] s, logic [15:0] e,
                              logic last);
      token_t t;
      if (pending_toks.size() == 0) begin
        $display("%0t: unexpected token, expected none, actual kind %0d start %0d end %0d",
                 $time, kind, s, e);
        errors++;
        return;
      end
      t = pending_toks.pop_front();
      compare_field("tok_kind", 16'(t.kind), 16'(kind));
      compare_field("tok_char", 16'(t.ch), 16'(ch));
      compare_field("tok_start", t.start_ofs, s);
      compare_field("tok_end", t.end_ofs, e);
      compare_field("last_of_run", 16'(t.last), 16'(last));
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni       = 1'b0;
  logic        src_valid_i  = 1'b0;
  logic        src_stall_o;
  logic [7:0]  src_byte_i   = 8'h00;
  logic        final_byte_i = 1'b0;
  logic        tok_valid_o;
  logic        tok_stall_i  = 1'b0;
  logic [2:0]  tok_kind_o;
  logic [7:0]  tok_char_o;
  logic [15:0] tok_start_o;
  logic [15:0] tok_end_o;
  logic        last_of_run_o;

  token_ledger ledger = new();
  int unsigned burst_left  = 0;
  int unsigned stall_left  = 0;
  int unsigned stall_phase = 0;
  int unsigned sent_count  = 0;

  source_tokenizer i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .src_valid_i   (src_valid_i),
    .src_stall_o   (src_stall_o),
    .src_byte_i    (src_byte_i),
    .final_byte_i  (final_byte_i),
    .tok_valid_o   (tok_valid_o),
    .tok_stall_i   (tok_stall_i),
    .tok_kind_o    (tok_kind_o),
    .tok_char_o    (tok_char_o),
    .tok_start_o   (tok_start_o),
    .tok_end_o     (tok_end_o),
    .last_of_run_o (last_of_run_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Sample both channels, then pick the next receiver stall
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (src_valid_i && src_stall_o === 1'b0) ledger.scan_byte(src_byte_i, final_byte_i);
      if (tok_valid_o === 1'b1 && !tok_stall_i)
        ledger.match_token(tok_kind_o, tok_char_o, tok_start_o, tok_end_o, last_of_run_o);
    end
    if (stall_left == 0) begin
      stall_phase = $urandom_range(0, 3);
      stall_left  = (stall_phase == 3) ? $urandom_range(1, 12) : $urandom_range(4, 48);
    end
    stall_left--;
    case (stall_phase)
      0:       tok_stall_i <= 1'b0;
      1:       tok_stall_i <= ($urandom_range(0, 3) == 0);
      2:       tok_stall_i <= 1'($urandom_range(0, 1));
      default: tok_stall_i <= 1'b1;
    endcase
  end

  // Bound the run
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("TEST FAILED");
    $finish;
  end

  // Offer one item and hold it until accepted
  task automatic push_byte(logic [7:0] c, logic fin);
    src_valid_i  <= 1'b1;
    src_byte_i   <= c;
    final_byte_i <= fin;
    do @(posedge clk_i); while (src_stall_o !== 1'b0);
    sent_count++;
  endtask

  task automatic pause_src(int unsigned n);
    src_valid_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // Send in bursts with random gaps between them
  task automatic paced_byte(logic [7:0] c, logic fin);
    if (burst_left == 0) begin
      pause_src($urandom_range(1, 6));
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 16);
    end
    burst_left--;
    push_byte(c, fin);
  endtask

  // Hold the sender until every owed token has arrived
  task automatic drain_tokens();
    src_valid_i <= 1'b0;
    @(posedge clk_i);
    while (ledger.outstanding() != 0) @(posedge clk_i);
  endtask

  task automatic send_text(string s, bit fin_at_end);
    for (int i = 0; i < s.len(); i++) push_byte(s[i], fin_at_end && i == s.len() - 1);
  endtask

  function automatic logic [7:0] pick_blank();
    int unsigned k;
    k = $urandom_range(0, 5);
    return (k == 5) ? 8'h20 : 8'(8'h09 + k);
  endfunction

  function automatic logic [7:0] pick_word(bit head);
    int unsigned k;
    k = $urandom_range(0, head ? 52 : 62);
    if (k < 26) return 8'(8'h61 + k);
    if (k < 52) return 8'(8'h41 + k - 26);
    if (k == 52) return CHAR_US;
    return 8'(8'h30 + k - 53);
  endfunction

  // Build a source from well-formed fragments mixed with noise, then send it
  task automatic send_random_source();
    logic [7:0] src_q[$];
    logic [7:0] c;
    string      punct;
    bit         ends;
    punct = "+-*/()[]{};,.=<>!";
    repeat ($urandom_range(1, 8)) begin
      case ($urandom_range(0, 9))
        0, 1: repeat ($urandom_range(1, 4)) src_q.push_back(pick_blank());
        2: begin
          src_q.push_back(CHAR_HASH);
          repeat ($urandom_range(0, 6)) begin
            c = 8'($urandom_range(0, 255));
            if (c == CHAR_NL) c = 8'h20;
            src_q.push_back(c);
          end
          if ($urandom_range(0, 3) != 0) src_q.push_back(CHAR_NL);
        end
        3, 4: begin
          src_q.push_back(pick_word(1'b1));
          repeat ($urandom_range(0, 6)) src_q.push_back(pick_word(1'b0));
        end
        5: repeat ($urandom_range(1, 5)) src_q.push_back(8'(8'h30 + $urandom_range(0, 9)));
        6: begin
          src_q.push_back(CHAR_QUOTE);
          repeat ($urandom_range(0, 6)) begin
            if ($urandom_range(0, 4) == 0) begin
              src_q.push_back(CHAR_BSLASH);
              src_q.push_back(8'($urandom_range(0, 255)));
            end else begin
              c = 8'($urandom_range(0, 255));
              if (c == CHAR_QUOTE || c == CHAR_BSLASH) c = 8'h41;
              src_q.push_back(c);
            end
          end
          if ($urandom_range(0, 7) != 0) src_q.push_back(CHAR_QUOTE);
        end
        7: src_q.push_back(punct[$urandom_range(0, punct.len() - 1)]);
        default: src_q.push_back(8'($urandom_range(0, 255)));
      endcase
    end
    // Leave some sources open so that the next one continues them
    ends = ($urandom_range(0, 7) != 0);
    foreach (src_q[i]) paced_byte(src_q[i], ends && i == src_q.size() - 1);
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: every token kind, escaped quote, byte extremes, unterminated escape
    send_text("_Z9 12#c\n\"\\\"\"", 1'b1);
    push_byte(8'h00, 1'b1);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h80, 1'b0);
    send_text("\"a\\", 1'b1);
    send_text("\015\t\013\014 ", 1'b1);
    drain_tokens();

    // Random sources with an occasional full drain
    while (sent_count < SRC_ITEMS) begin
      send_random_source();
      if ($urandom_range(0, 24) == 0) drain_tokens();
    end

    // Wait out the owed tokens plus pipeline latency
    src_valid_i <= 1'b0;
    @(posedge clk_i);
    while (ledger.outstanding() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (ledger.errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end
endmodule
